>>> rtl/core/derp_pkg.sv
// shared types, codes and the head offset table of the error recovery sequencer
`timescale 1ns / 1ps
package derp_pkg;

	localparam int CYL_W   = 10;
	localparam int COUNT_W = 5;
	localparam int OFS_W   = 13;
	localparam int IDX_W   = 1;

	localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST  = 5'd27;
	localparam logic [COUNT_W-1:0] OFFSET_START_RST = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_TOP        = 5'd31;
	localparam logic [2:0]         RECAL_SLOT       = 3'd4;
	localparam logic [OFS_W-1:0]   OFS_FMT          = 13'o10000;

	localparam logic [IDX_W-1:0] REG_RETRY_LIMIT  = 1'b0;
	localparam logic [IDX_W-1:0] REG_OFFSET_START = 1'b1;

	typedef enum logic [2:0] {
		ACT_ECC    = 3'd0,
		ACT_RECAL  = 3'd1,
		ACT_SEEK   = 3'd2,
		ACT_OFFSET = 3'd3,
		ACT_RETRY  = 3'd4,
		ACT_DONE   = 3'd5
	} action_t;

	// recalibration sequence position, one-hot
	typedef enum logic [3:0] {
		PH_NONE   = 4'b0001,
		PH_SEEK   = 4'b0010,
		PH_OFFSET = 4'b0100,
		PH_LAST   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic             drive_error;
		logic             write_locked;
		logic             data_check;
		logic             ecc_hard;
		logic             is_read;
		logic             words_left_zero;
		logic [CYL_W-1:0] target_cylinder;
	} item_t;

	typedef struct packed {
		logic [2:0]         action;
		logic               clear_drive;
		logic               return_center;
		logic               failed;
		logic [OFS_W-1:0]   offset_value;
		logic [CYL_W-1:0]   seek_cylinder;
		logic [COUNT_W-1:0] error_count;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		phase_t             phase;
		logic               fail_mark;
	} recovery_state_t;

	function automatic logic [OFS_W-1:0] offset_lookup(input logic [3:0] idx);
		logic [OFS_W-1:0] v;
		unique case (idx)
			4'd0, 4'd2:   v = 13'o0020;
			4'd1, 4'd3:   v = 13'o0220;
			4'd4, 4'd6:   v = 13'o0040;
			4'd5, 4'd7:   v = 13'o0240;
			4'd8, 4'd10:  v = 13'o0060;
			4'd9, 4'd11:  v = 13'o0260;
			default:      v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/derp_decide.sv
// next-command decision for one completion interrupt
`timescale 1ns / 1ps
module derp_decide import derp_pkg::*; (
	input  item_t                 item,
	input  recovery_state_t       cur,
	input  logic [COUNT_W-1:0]    retry_limit,
	input  logic [COUNT_W-1:0]    offset_start,
	output result_t               result,
	output recovery_state_t       nxt
);

	logic [COUNT_W:0]   inc;
	logic [COUNT_W-1:0] cnt;
	logic               fmark;
	logic               active;
	logic               decided;
	action_t            act;
	phase_t             phase;
	logic               rtc;
	logic               fail_out;
	logic [OFS_W-1:0]   ofs;
	logic [CYL_W-1:0]   seek;
	logic               past_start;

	always_comb begin
		inc      = {1'b0, cur.count} + {{COUNT_W{1'b0}}, 1'b1};
		cnt      = cur.count;
		fmark    = cur.fail_mark;
		phase    = cur.phase;
		active   = 1'b1;
		decided  = 1'b0;
		act      = ACT_RETRY;
		rtc      = 1'b0;
		fail_out = 1'b0;
		ofs      = '0;
		seek     = '0;

		if (item.drive_error) begin
			if (item.write_locked) begin
				fmark = 1'b1;
			end else begin
				// saturate the stored count, compare the full sum
				cnt = inc[COUNT_W] ? COUNT_TOP : inc[COUNT_W-1:0];
				if (inc > {1'b0, retry_limit}) begin
					fmark = 1'b1;
				end else begin
					active = 1'b0;
					if (item.data_check && !item.ecc_hard) begin
						active = 1'b1;
						if (!item.words_left_zero) begin
							act     = ACT_ECC;
							decided = 1'b1;
						end
					end
				end
			end
			if (!decided && cnt[2:0] == RECAL_SLOT && !active) begin
				act     = ACT_RECAL;
				phase   = PH_SEEK;
				decided = 1'b1;
			end
		end

		past_start = cnt >= offset_start;

		if (!decided) begin
			unique case (cur.phase)
				PH_SEEK: begin
					act     = ACT_SEEK;
					seek    = item.target_cylinder;
					phase   = PH_OFFSET;
					decided = 1'b1;
				end
				PH_OFFSET: begin
					if (past_start && item.is_read) begin
						act     = ACT_OFFSET;
						ofs     = offset_lookup(cnt[3:0]) | OFS_FMT;
						phase   = PH_LAST;
						decided = 1'b1;
					end else begin
						phase  = PH_NONE;
						active = 1'b0;
					end
				end
				PH_LAST: begin
					phase  = PH_NONE;
					active = 1'b0;
				end
				default: begin
				end
			endcase
		end

		if (!decided) begin
			if (active) begin
				act      = ACT_DONE;
				rtc      = past_start;
				fail_out = fmark;
				cnt      = '0;
				fmark    = 1'b0;
			end else begin
				act = ACT_RETRY;
			end
		end
	end

	always_comb begin
		result.action        = act;
		result.clear_drive   = item.drive_error;
		result.return_center = rtc;
		result.failed        = fail_out;
		result.offset_value  = ofs;
		result.seek_cylinder = seek;
		result.error_count   = cnt;
		nxt.count            = cnt;
		nxt.phase            = phase;
		nxt.fail_mark        = fmark;
	end

endmodule

>>> rtl/core/disk_error_recovery_sequencer.sv
// Disk error recovery sequencer: one completion interrupt in, one next command out.
// Interrupt items arrive on item/item_valid; a transfer happens at a clock edge with
// item_valid high and item_stall low. Commands leave on result/result_valid and
// transfer at an edge with result_valid high and result_stall low.
// Each item is captured in an input register, decided by a short block of compare
// and table logic, and written to the result register together with the retry
// counter, recalibration phase and failure mark, so results appear in input order.
// Path: an item that transfers enters the input register, moves to the result register
// when that is empty or its command leaves, and its command can transfer from there.
// Throughput: one item per cycle while the receiver does not stall.
// When result_stall is held the result register keeps its command, the input
// register holds one more item and item_stall rises once both are full.
// Configuration: cfg_index 0 writes retry_limit, 1 writes offset_start; cfg_ready
// is always high and writes take effect at once. Write only while no item is in
// flight.
// Reset (arst_n low) empties both registers, clears the counter, phase and failure
// mark, and restores retry_limit to 27 and offset_start to 16.
`timescale 1ns / 1ps
module disk_error_recovery_sequencer import derp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic               valid_s1;
	item_t              item_s1;
	logic               valid_s2;
	result_t            result_s2;
	recovery_state_t    state_q;
	recovery_state_t    state_nxt;
	result_t            result_nxt;
	logic [COUNT_W-1:0] retry_limit_q;
	logic [COUNT_W-1:0] offset_start_q;
	logic               advance;

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && valid_s2 && result_stall;
	assign cfg_ready  = 1'b1;

	derp_decide u_decide (
		.item         (item_s1),
		.cur          (state_q),
		.retry_limit  (retry_limit_q),
		.offset_start (offset_start_q),
		.result       (result_nxt),
		.nxt          (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '{count: '0, phase: PH_NONE, fail_mark: 1'b0};
		end else if (advance) begin
			valid_s2 <= 1'b1;
			state_q  <= state_nxt;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q  <= RETRY_LIMIT_RST;
			offset_start_q <= OFFSET_START_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RETRY_LIMIT:  retry_limit_q  <= cfg_data;
				REG_OFFSET_START: offset_start_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// completion always leaves the counter cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == ACT_DONE |-> result.error_count == '0)
		else $error("completion left a nonzero retry count");

	// centre return and failure only ride on a completion
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action != ACT_DONE |-> !result.return_center && !result.failed)
		else $error("completion flags on a non-completion command");

	// an offset command always carries the offset format bit
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == ACT_OFFSET |-> result.offset_value[OFS_W-1])
		else $error("offset command without format bit");

	// the decision state moves only when an item passes to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("recovery state changed without an item");

endmodule

>>> sim/tb_disk_error_recovery_sequencer.sv
// self-checking testbench for the disk error recovery sequencer: directed table, then random phases
`timescale 1ns / 1ps
module tb_disk_error_recovery_sequencer;
	import derp_pkg::*;

	// flag bits of an interrupt, in the order of the packed item
	localparam logic [5:0] F_ERR   = 6'b100000;
	localparam logic [5:0] F_WLK   = 6'b010000;
	localparam logic [5:0] F_DCHK  = 6'b001000;
	localparam logic [5:0] F_EHARD = 6'b000100;
	localparam logic [5:0] F_READ  = 6'b000010;
	localparam logic [5:0] F_WZERO = 6'b000001;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 180;
	localparam int CHOKE_HOLD  = 250;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	item_t              item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [COUNT_W-1:0] cfg_data = '0;

	disk_error_recovery_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the sequencer state and registers
	logic [COUNT_W-1:0] tries;
	phase_t             recal_step;
	logic               failing;
	logic [COUNT_W-1:0] limit_cfg;
	logic [COUNT_W-1:0] start_cfg;

	result_t pending_cmds[$];
	int      errors = 0;
	bit      choke = 1'b0;
	bit      send_quiet = 1'b0;

	typedef struct {
		bit                 cfg_write;
		logic [IDX_W-1:0]   reg_idx;
		logic [COUNT_W-1:0] reg_val;
		item_t              irq;
		bit                 typed;
		result_t            want;
	} step_t;

	step_t plan[$];

	function automatic result_t next_command(input item_t irq);
		result_t    r;
		logic [5:0] bumped;
		logic       busy;
		logic       done;
		r = '0;
		r.action = ACT_RETRY;
		busy = 1'b1;
		done = 1'b0;
		if (irq.drive_error) begin
			if (irq.write_locked) begin
				failing = 1'b1;
			end else begin
				bumped = {1'b0, tries} + 6'd1;
				tries = (bumped > {1'b0, COUNT_TOP}) ? COUNT_TOP : bumped[COUNT_W-1:0];
				// the unsaturated count decides the hard failure
				if (bumped > {1'b0, limit_cfg}) begin
					failing = 1'b1;
				end else begin
					busy = 1'b0;
					if (irq.data_check && !irq.ecc_hard) begin
						busy = 1'b1;
						if (!irq.words_left_zero) begin
							r.action = ACT_ECC;
							done = 1'b1;
						end
					end
				end
			end
			if (!done && !busy && tries[2:0] == RECAL_SLOT) begin
				r.action = ACT_RECAL;
				recal_step = PH_SEEK;
				done = 1'b1;
			end
		end
		if (!done) begin
			if (recal_step == PH_SEEK) begin
				r.action = ACT_SEEK;
				r.seek_cylinder = irq.target_cylinder;
				recal_step = PH_OFFSET;
				done = 1'b1;
			end else if (recal_step == PH_OFFSET && tries >= start_cfg && irq.is_read) begin
				r.action = ACT_OFFSET;
				// 020/040/060 by group of four counts, plus 0200 on odd counts; top quarter is zero
				r.offset_value = OFS_FMT;
				if (tries[3:2] != 2'b11)
					r.offset_value = r.offset_value | (({11'd0, tries[3:2]} + 13'd1) << 4)
						| (tries[0] ? 13'o200 : 13'o0);
				recal_step = PH_LAST;
				done = 1'b1;
			end else if (recal_step != PH_NONE) begin
				recal_step = PH_NONE;
				busy = 1'b0;
			end
		end
		if (!done) begin
			if (busy) begin
				r.action = ACT_DONE;
				r.return_center = (tries >= start_cfg);
				r.failed = failing;
				tries = '0;
				failing = 1'b0;
			end else begin
				r.action = ACT_RETRY;
			end
		end
		r.clear_drive = irq.drive_error;
		r.error_count = tries;
		return r;
	endfunction

	function automatic result_t cmd(input action_t a, input logic clr, input logic rtc,
		input logic fl, input logic [OFS_W-1:0] ofs, input logic [CYL_W-1:0] sk,
		input logic [COUNT_W-1:0] n);
		return {a, clr, rtc, fl, ofs, sk, n};
	endfunction

	function automatic void plan_irq(input item_t irq, input bit typed, input result_t want);
		step_t s;
		s = '{cfg_write: 1'b0, reg_idx: '0, reg_val: '0, irq: irq, typed: typed, want: want};
		plan.push_back(s);
	endfunction

	function automatic void plan_reg(input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		step_t s;
		s = '{cfg_write: 1'b1, reg_idx: idx, reg_val: val, irq: '0, typed: 1'b0, want: '0};
		plan.push_back(s);
	endfunction

	function automatic item_t random_irq(input int err_pct);
		item_t x;
		x.drive_error     = ($urandom_range(0, 99) < err_pct);
		x.write_locked    = ($urandom_range(0, 19) == 0);
		x.data_check      = ($urandom_range(0, 4) < 2);
		x.ecc_hard        = ($urandom_range(0, 9) < 3);
		x.is_read         = 1'($urandom_range(0, 1));
		x.words_left_zero = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 9))
			0:       x.target_cylinder = '0;
			1:       x.target_cylinder = '1;
			default: x.target_cylinder = CYL_W'($urandom_range(0, 1023));
		endcase
		return x;
	endfunction

	// offer one interrupt after a random gap and record what it should produce
	task automatic push_item(input item_t irq, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		if ($urandom_range(0, 29) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = irq;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		predicted = next_command(irq);
		pending_cmds.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// register writes only once every command has drained
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
		item_valid = 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == REG_RETRY_LIMIT)
			limit_cfg = val;
		else
			start_cfg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stall before each transfer, one long hold-off on request
	initial begin : receiver
		int hold;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				quiet = !quiet;
			hold = quiet ? 0 : $urandom_range(0, 14);
			if (choke) begin
				choke = 1'b0;
				hold = CHOKE_HOLD;
			end
			if (hold > 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			@(negedge clk);
		end
	end

	function automatic bit field_bad(input string fname, input logic [OFS_W-1:0] got,
		input logic [OFS_W-1:0] want);
		if (got === want)
			return 1'b0;
		if (errors < 10)
			$display("%0t ns: %s expected %0d got %0d", $time, fname, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk) begin : check_result
		result_t want;
		bit      bad;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_cmds.size() == 0) begin
				if (errors < 10)
					$display("%0t ns: command with nothing expected: %h", $time, result);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				bad = field_bad("action", OFS_W'(result.action), OFS_W'(want.action))
					| field_bad("clear_drive", OFS_W'(result.clear_drive),
						OFS_W'(want.clear_drive))
					| field_bad("return_center", OFS_W'(result.return_center),
						OFS_W'(want.return_center))
					| field_bad("failed", OFS_W'(result.failed), OFS_W'(want.failed))
					| field_bad("offset_value", result.offset_value, want.offset_value)
					| field_bad("seek_cylinder", OFS_W'(result.seek_cylinder),
						OFS_W'(want.seek_cylinder))
					| field_bad("error_count", OFS_W'(result.error_count),
						OFS_W'(want.error_count));
				if (bad)
					errors++;
			end
		end
	end

	initial begin : watchdog
		#5000000;
		$display("disk_error_recovery_sequencer regression: fail");
		$finish;
	end

	initial begin : sender
		int    lim_set[4] = '{31, 1, 31, 8};
		int    start_set[4] = '{0, 31, 31, 4};
		int    err_pct[PHASES] = '{35, 80, 97, 60, 95, 20, 85, 97};
		int    drain;
		step_t s;

		tries = '0;
		recal_step = PH_NONE;
		failing = 1'b0;
		limit_cfg = RETRY_LIMIT_RST;
		start_cfg = OFFSET_START_RST;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset values: completion, write lock, retry, ecc resume, recalibration
		plan_irq({6'b000000, 10'd0}, 1, cmd(ACT_DONE, 0, 0, 0, 0, 0, 0));
		plan_irq({F_ERR | F_WLK, 10'd1023}, 1, cmd(ACT_DONE, 1, 0, 1, 0, 0, 0));
		plan_irq({F_ERR, 10'd3}, 1, cmd(ACT_RETRY, 1, 0, 0, 0, 0, 1));
		plan_irq({F_ERR | F_DCHK, 10'd4}, 1, cmd(ACT_ECC, 1, 0, 0, 0, 0, 2));
		plan_irq({F_ERR | F_DCHK | F_EHARD | F_READ, 10'd5}, 0, '0);
		plan_irq({F_ERR | F_READ, 10'd6}, 1, cmd(ACT_RECAL, 1, 0, 0, 0, 0, 4));
		// error while recalibrating, then the sequence carries on
		plan_irq({F_ERR | F_READ, 10'd700}, 0, '0);
		plan_irq({F_READ, 10'd8}, 0, '0);
		plan_irq({F_WZERO, 10'd9}, 0, '0);
		// correctable check with no words left completes instead
		plan_irq({F_ERR | F_DCHK | F_WZERO, 10'd10}, 0, '0);
		plan_reg(REG_OFFSET_START, 5'd0);
		plan_reg(REG_RETRY_LIMIT, 5'd1);
		plan_irq({F_ERR, 10'd11}, 1, cmd(ACT_RETRY, 1, 0, 0, 0, 0, 1));
		plan_irq({F_ERR | F_READ, 10'd12}, 1, cmd(ACT_DONE, 1, 1, 1, 0, 0, 0));
		plan_reg(REG_RETRY_LIMIT, 5'd31);
		repeat (4) plan_irq({F_ERR, 10'd13}, 0, '0);
		plan_irq({F_READ, 10'd682}, 0, '0);
		plan_irq({F_READ, 10'd0}, 1, cmd(ACT_OFFSET, 0, 0, 0, 13'o10040, 0, 4));
		// after the offset step the sequence ends in a retry
		plan_irq({6'b000000, 10'd1}, 0, '0);
		plan_irq({F_READ | F_WZERO, 10'd1023}, 1, cmd(ACT_DONE, 0, 1, 0, 0, 0, 0));
		plan_irq({6'b111111, 10'd1023}, 1, cmd(ACT_DONE, 1, 1, 1, 0, 0, 0));

		foreach (plan[i]) begin
			s = plan[i];
			if (s.cfg_write)
				write_reg(s.reg_idx, s.reg_val);
			else
				push_item(s.irq, s.typed, s.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				write_reg(REG_RETRY_LIMIT, COUNT_W'(lim_set[p]));
				write_reg(REG_OFFSET_START, COUNT_W'(start_set[p]));
			end else begin
				write_reg(REG_RETRY_LIMIT, COUNT_W'($urandom_range(1, 31)));
				write_reg(REG_OFFSET_START, COUNT_W'($urandom_range(0, 31)));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off so the input side backs up
				if ((p == 2 || p == 5) && n == 60)
					choke = 1'b1;
				push_item(random_irq(err_pct[p]), 0, '0);
			end
		end
		item_valid = 1'b0;

		drain = 0;
		while (pending_cmds.size() != 0 && drain < 2000) begin
			@(negedge clk);
			drain++;
		end
		repeat (4) @(negedge clk);
		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("disk_error_recovery_sequencer regression: pass");
		end else begin
			$display("disk_error_recovery_sequencer regression: fail");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/derp_pkg.sv
rtl/core/derp_decide.sv
rtl/core/disk_error_recovery_sequencer.sv
sim/tb_disk_error_recovery_sequencer.sv
